// ===== rtl/assert_macros.svh =====
// assertion helpers, each expects clk_i and rst_ni in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ohash_pkg.sv =====
package ohash_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W   = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'b1;

  // probe modes, the unused code behaves as linear
  localparam logic [MODE_W-1:0] PROBE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] PROBE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] PROBE_DOUBLE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd13;

  // result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

  // item actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  found_value;
  } result_t;

  typedef enum logic [2:0] {
    OH_CLEAR,
    OH_IDLE,
    OH_DIV,
    OH_HOME,
    OH_READ,
    OH_CHECK
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic div_step;
    logic home;
    logic check;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic key_zero;
    logic div_last;
    logic probe_done;
  } stat_t;

endpackage

// ===== rtl/open_address_hash_table_top.sv =====
// open-addressing hash table, one result strobe on done_o per accepted item
// sequence: key 0 is finished in the remainder state entered after the start transfer
//   and answered through the result register; otherwise the bit-serial remainder pass,
//   a home step, a read and a check per probed slot, then the result register
// throughput: one item at a time; busy falls as the result strobe rises
// reset: asynchronous, then a clearing pass over all TABLE_DEPTH slots; receiver cannot stall
module open_address_hash_table_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  ohash_pkg::item_t                item_i,
  input  logic                            cfg_we_i,
  input  logic [ohash_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ohash_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                            done_o,
  output ohash_pkg::result_t              result_o
);

  ohash_pkg::cmd_t  cmd;
  ohash_pkg::stat_t stat;

  // sequencing
  ohash_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // remainders, probing, slot store and result register
  ohash_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

// ===== rtl/ohash_ctrl.sv =====
`include "assert_macros.svh"

module ohash_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ohash_pkg::stat_t stat_i,
  output ohash_pkg::cmd_t  cmd_o,
  output logic             busy_o
);

  ohash_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ohash_pkg::OH_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ohash_pkg::OH_CLEAR: begin
        if (stat_i.clear_last) state_d = ohash_pkg::OH_IDLE;
      end
      ohash_pkg::OH_IDLE: begin
        if (start_i) state_d = ohash_pkg::OH_DIV;
      end
      ohash_pkg::OH_DIV: begin
        priority if (stat_i.key_zero) state_d = ohash_pkg::OH_IDLE;
        else if (stat_i.div_last) state_d = ohash_pkg::OH_HOME;
      end
      ohash_pkg::OH_HOME: state_d = ohash_pkg::OH_READ;
      ohash_pkg::OH_READ: state_d = ohash_pkg::OH_CHECK;
      ohash_pkg::OH_CHECK: begin
        state_d = stat_i.probe_done ? ohash_pkg::OH_IDLE : ohash_pkg::OH_READ;
      end
      default: state_d = ohash_pkg::OH_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ohash_pkg::OH_CLEAR: cmd_o.clear = 1'b1;
      ohash_pkg::OH_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ohash_pkg::OH_DIV: begin
        cmd_o.div_step = !stat_i.key_zero;
        cmd_o.finish   = stat_i.key_zero;
      end
      ohash_pkg::OH_HOME: cmd_o.home = 1'b1;
      ohash_pkg::OH_READ: cmd_o = '0;
      ohash_pkg::OH_CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.finish = stat_i.probe_done;
      end
      default: cmd_o = '0;
    endcase
  end

  // an accepted item always starts with the remainder pass
  `ASSERT_NEXT(a_accept_div, cmd_o.accept, state_q == ohash_pkg::OH_DIV, "accept without divide")
  // a transfer is taken only while idle
  `ASSERT_SAME(a_accept_idle, cmd_o.accept, !busy_o && start_i, "accept while busy")
  // every finished item hands control back to idle
  `ASSERT_NEXT(a_finish_idle, cmd_o.finish, state_q == ohash_pkg::OH_IDLE, "no return to idle")

endmodule

// ===== rtl/ohash_dp.sv =====
`include "assert_macros.svh"

module ohash_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ohash_pkg::cmd_t                     cmd_i,
  output ohash_pkg::stat_t                    stat_o,
  input  ohash_pkg::item_t                    item_i,
  input  logic                                cfg_we_i,
  input  logic [ohash_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ohash_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                                done_o,
  output ohash_pkg::result_t                  result_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW = ohash_pkg::SIZE_W;
  localparam int unsigned KW = ohash_pkg::KEY_W;
  localparam int unsigned VW = ohash_pkg::VAL_W;
  // largest usable size: bounded by the depth and the size register range
  localparam logic [SW-1:0] SMAX = SW'((TABLE_DEPTH < 31) ? TABLE_DEPTH : 31);
  localparam logic [SW-1:0] DIV_LAST = SW'(KW - 1);

  // a + b mod m, both operands below m
  function automatic logic [SW-1:0] mod_add(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b,
                                            input logic [SW-1:0] m);
    logic [SW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[SW-1:0];
  endfunction

  // configuration registers
  logic [SW-1:0]                    table_size_q;
  logic [ohash_pkg::MODE_W-1:0]     probe_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= ohash_pkg::SIZE_RESET;
      probe_mode_q <= ohash_pkg::PROBE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ohash_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_data_i;
        ohash_pkg::CFG_PROBE_MODE: probe_mode_q <= cfg_data_i[ohash_pkg::MODE_W-1:0];
        default: table_size_q <= table_size_q;
      endcase
    end
  end

  // effective size saturated into the usable range
  logic [SW-1:0] s_eff;
  always_comb begin
    priority if (table_size_q < SW'(2)) s_eff = SW'(2);
    else if (table_size_q > SMAX) s_eff = SMAX;
    else s_eff = table_size_q;
  end

  logic mode_quad, mode_dbl;
  assign mode_quad = (probe_mode_q == ohash_pkg::PROBE_QUAD);
  assign mode_dbl  = (probe_mode_q == ohash_pkg::PROBE_DOUBLE);

  // item registers
  logic          action_q;
  logic [KW-1:0] key_q, key_sh_q;
  logic [VW-1:0] value_q;

  // bit-serial remainders of key by s and by s-1
  logic [SW-1:0] rem_a_q, rem_b_q, div_cnt_q;
  logic [SW-1:0] div_b;
  logic [SW:0]   r_a, r_b;

  assign div_b = s_eff - SW'(1);
  assign r_a   = {rem_a_q, key_sh_q[KW-1]};
  assign r_b   = {rem_b_q, key_sh_q[KW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= item_i.action;
      key_q    <= item_i.key;
      value_q  <= item_i.value;
      key_sh_q <= item_i.key;
      rem_a_q  <= '0;
      rem_b_q  <= '0;
    end else if (cmd_i.div_step) begin
      key_sh_q <= {key_sh_q[KW-2:0], 1'b0};
      rem_a_q  <= (r_a >= {1'b0, s_eff}) ? SW'(r_a - {1'b0, s_eff}) : r_a[SW-1:0];
      rem_b_q  <= (r_b >= {1'b0, div_b}) ? SW'(r_b - {1'b0, div_b}) : r_b[SW-1:0];
    end
  end

  // divide step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + SW'(1);
    end
  end

  // probe state
  logic [SW-1:0] idx_q, start_q, step_q, n_q, sq_q, odd_q;
  logic [SW-1:0] add, nidx;

  always_comb begin
    priority if (mode_quad) add = sq_q;
    else if (mode_dbl) add = step_q;
    else add = SW'(1);
  end
  assign nidx = mod_add(idx_q, add, s_eff);

  // slot memory
  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [VW-1:0] val_mem [TABLE_DEPTH];
  logic [KW-1:0] rd_key_q;
  logic [VW-1:0] rd_val_q;
  logic [AW-1:0] clr_cnt_q, waddr;
  logic          mem_we, slot_empty, slot_hit;

  assign slot_empty = (rd_key_q == '0);
  assign slot_hit   = (rd_key_q == key_q);
  assign mem_we     = cmd_i.clear || (cmd_i.check && (action_q == ohash_pkg::ACT_INSERT)
                                      && slot_empty);
  assign waddr      = cmd_i.clear ? clr_cnt_q : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[waddr] <= cmd_i.clear ? '0 : key_q;
      val_mem[waddr] <= cmd_i.clear ? '0 : value_q;
    end
    rd_key_q <= key_mem[AW'(idx_q)];
    rd_val_q <= val_mem[AW'(idx_q)];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // probe termination and outcome
  logic                         last_probe, back_home, probe_done;
  logic [ohash_pkg::STAT_W-1:0] probe_status;

  assign last_probe = (n_q == s_eff);
  assign back_home  = !mode_quad && (nidx == start_q);

  always_comb begin
    if (action_q == ohash_pkg::ACT_INSERT) begin
      probe_done   = slot_empty || last_probe;
      probe_status = slot_empty ? ohash_pkg::ST_INSERTED : ohash_pkg::ST_FULL;
    end else begin
      probe_done   = slot_empty || slot_hit || last_probe || back_home;
      probe_status = (slot_hit && !slot_empty) ? ohash_pkg::ST_FOUND
                                               : ohash_pkg::ST_NOT_FOUND;
    end
  end

  // probe sequence registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.home) begin
      idx_q <= rem_a_q;
    end else if (cmd_i.check && !probe_done) begin
      idx_q <= nidx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.home) begin
      start_q <= rem_a_q;
      step_q  <= rem_b_q + SW'(1);
      n_q     <= SW'(1);
      sq_q    <= SW'(1);
      odd_q   <= (s_eff > SW'(3)) ? SW'(3) : SW'(3) - s_eff;
    end else if (cmd_i.check && !probe_done) begin
      n_q   <= n_q + SW'(1);
      sq_q  <= mod_add(sq_q, odd_q, s_eff);
      odd_q <= mod_add(odd_q, SW'(2), s_eff);
    end
  end

  // result register and strobe
  logic                         done_q;
  logic [ohash_pkg::STAT_W-1:0] status_q;
  logic [VW-1:0]                found_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q      <= stat_o.key_zero ? ohash_pkg::ST_INVALID : probe_status;
      found_value_q <= (!stat_o.key_zero && (action_q == ohash_pkg::ACT_SEARCH)
                        && slot_hit && !slot_empty) ? rd_val_q : '0;
    end
  end

  assign done_o               = done_q;
  assign result_o.status      = status_q;
  assign result_o.found_value = found_value_q;

  assign stat_o.clear_last = (clr_cnt_q == AW'(TABLE_DEPTH - 1));
  assign stat_o.key_zero   = (key_q == '0);
  assign stat_o.div_last   = (div_cnt_q == DIV_LAST);
  assign stat_o.probe_done = probe_done;

  // probe index stays inside the active table
  `ASSERT_SAME(a_idx_range, cmd_i.check, idx_q < s_eff, "probe index out of range")
  // only an insert or the clearing pass writes the store
  `ASSERT_SAME(a_we_insert, mem_we && !cmd_i.clear, action_q == ohash_pkg::ACT_INSERT, "write on search")
  // value is zero unless the key was found
  `ASSERT_SAME(a_fv_zero, done_q && (status_q != ohash_pkg::ST_FOUND), found_value_q == '0, "stray value")

endmodule
